// ----- rtl/fwsl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsl_pkg: shared types and constants of the five-way press classifier
// Holds the phase encoding, button codes, register indexes and the small
// mapping functions used by the classifier core.
// ----------------------------------------------------------------------------
package fwsl_pkg;

   localparam int COUNTER_WIDTH = 16;
   localparam int CMP_WIDTH     = (COUNTER_WIDTH > 16) ? COUNTER_WIDTH : 16;
   localparam int LINES         = 5;

   localparam logic [7:0]  SETTLE_RESET = 8'd50;
   localparam logic [15:0] LONG_RESET   = 16'd950;

   // Register indexes on the configuration port (byte address bit 2).
   localparam logic REG_SETTLE = 1'b0;
   localparam logic REG_LONG   = 1'b1;

   // Button codes.
   localparam logic [2:0] BTN_NONE   = 3'd0;
   localparam logic [2:0] BTN_UP     = 3'd1;
   localparam logic [2:0] BTN_RIGHT  = 3'd2;
   localparam logic [2:0] BTN_DOWN   = 3'd3;
   localparam logic [2:0] BTN_LEFT   = 3'd4;
   localparam logic [2:0] BTN_CENTER = 3'd5;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_SETTLE = 2'd1,
      PH_TIMING = 2'd2,
      PH_WAIT   = 2'd3
   } phase_type;

   typedef struct packed {
      logic [7:0]  settle_ticks;
      logic [15:0] long_ticks;
   } cfg_type;

   // Lowest set line wins when several rise together.
   function automatic logic [2:0] lowest_code(input logic [LINES-1:0] bits);
      logic [2:0] code;
      code = BTN_NONE;
      if (bits[4]) code = BTN_CENTER;
      if (bits[3]) code = BTN_LEFT;
      if (bits[2]) code = BTN_DOWN;
      if (bits[1]) code = BTN_RIGHT;
      if (bits[0]) code = BTN_UP;
      return code;
   endfunction

   // Long-press priority: right, up, down, left, center.
   function automatic logic [2:0] long_code(input logic [LINES-1:0] lv);
      logic [2:0] code;
      code = BTN_NONE;
      if (lv[4]) code = BTN_CENTER;
      if (lv[3]) code = BTN_LEFT;
      if (lv[2]) code = BTN_DOWN;
      if (lv[0]) code = BTN_UP;
      if (lv[1]) code = BTN_RIGHT;
      return code;
   endfunction

endpackage

// ----- rtl/fwsl_csr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsl_csr: configuration registers
// APB-style register file holding the settle and long-press limits.
// ----------------------------------------------------------------------------
module fwsl_csr
   import fwsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   logic [7:0]  settle_ff, settle_in;
   logic [15:0] long_ff, long_in;
   logic        wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      settle_in = settle_ff;
      long_in   = long_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_SETTLE: settle_in = csr_pwdata[7:0];
            REG_LONG:   long_in   = csr_pwdata[15:0];
            default:    ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_ff <= SETTLE_RESET;
         long_ff   <= LONG_RESET;
      end else begin
         settle_ff <= settle_in;
         long_ff   <= long_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         REG_SETTLE: csr_prdata = {24'd0, settle_ff};
         REG_LONG:   csr_prdata = {16'd0, long_ff};
         default:    csr_prdata = 32'd0;
      endcase
   end

   assign cfg.settle_ticks = settle_ff;
   assign cfg.long_ticks   = long_ff;

endmodule

// ----- rtl/fwsl_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsl_core: press classifier step and result register
// Takes one registered tick, updates phase and hold counter, and loads a
// press event into the result register.
// ----------------------------------------------------------------------------
module fwsl_core
   import fwsl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             tick_valid,
   input  logic [LINES-1:0] tick_levels,
   output logic             tick_take,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [2:0]       rsp_button_code,
   output logic             rsp_long_press
);

   localparam logic [COUNTER_WIDTH-1:0] CNT_MAX = {COUNTER_WIDTH{1'b1}};

   phase_type                phase_ff, phase_in;
   logic [LINES-1:0]         prev_ff, prev_in;
   logic [2:0]               active_ff, active_in;
   logic [COUNTER_WIDTH-1:0] tick_ff, tick_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [2:0]               code_ff, code_in;
   logic                     long_ff, long_in;

   logic [LINES-1:0]         rise;
   logic [COUNTER_WIDTH-1:0] tick_up;
   logic [CMP_WIDTH-1:0]     tick_up_x, settle_x, limit_x;
   logic                     held;
   logic                     emit;
   logic [2:0]               emit_code;
   logic                     emit_long;
   logic [2:0]               lcode;

   assign tick_take = tick_valid & (~rsp_valid_ff | rsp_ready);
   assign rise      = tick_levels & ~prev_ff;
   assign tick_up   = (tick_ff == CNT_MAX) ? tick_ff : tick_ff + 1'b1;
   assign tick_up_x = CMP_WIDTH'(tick_up);
   assign settle_x  = CMP_WIDTH'(cfg.settle_ticks);
   assign limit_x   = (cfg.long_ticks == 16'd0) ? CMP_WIDTH'(1) : CMP_WIDTH'(cfg.long_ticks);
   assign lcode     = long_code(tick_levels);

   always_comb begin
      case (active_ff)
         BTN_UP:     held = tick_levels[0];
         BTN_RIGHT:  held = tick_levels[1];
         BTN_DOWN:   held = tick_levels[2];
         BTN_LEFT:   held = tick_levels[3];
         BTN_CENTER: held = tick_levels[4];
         default:    held = 1'b0;
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      prev_in   = prev_ff;
      active_in = active_ff;
      tick_in   = tick_ff;
      emit      = 1'b0;
      emit_code = active_ff;
      emit_long = 1'b0;
      if (tick_take) begin
         prev_in = tick_levels;
         case (phase_ff)
            PH_IDLE: begin
               if (rise != '0) begin
                  active_in = lowest_code(rise);
                  tick_in   = '0;
                  phase_in  = (cfg.settle_ticks != 8'd0) ? PH_SETTLE : PH_TIMING;
               end
            end
            PH_SETTLE: begin
               tick_in = tick_up;
               if (tick_up_x >= settle_x) begin
                  tick_in  = '0;
                  phase_in = PH_TIMING;
               end
            end
            PH_TIMING: begin
               if (!held) begin
                  emit     = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  tick_in = tick_up;
                  if (tick_up_x >= limit_x) begin
                     emit      = (lcode != BTN_NONE);
                     emit_code = lcode;
                     emit_long = 1'b1;
                     phase_in  = PH_WAIT;
                  end
               end
            end
            PH_WAIT: begin
               if (!held) phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   // The result register is reloaded on every tick taken; otherwise it
   // empties once the beat has been taken downstream.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      code_in      = code_ff;
      long_in      = long_ff;
      if (tick_take) begin
         rsp_valid_in = emit;
         code_in      = emit_code;
         long_in      = emit_long;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         prev_ff      <= '0;
         active_ff    <= BTN_NONE;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         prev_ff      <= prev_in;
         active_ff    <= active_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      long_ff <= long_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_button_code = code_ff;
   assign rsp_long_press  = long_ff;

   a_active_known: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_IDLE |-> (active_ff >= BTN_UP && active_ff <= BTN_CENTER))
      else $error("active button out of range during a press");

   a_settle_bound: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SETTLE |-> CMP_WIDTH'(tick_ff) < CMP_WIDTH'(cfg.settle_ticks))
      else $error("settle count reached its limit without leaving settle");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> $stable(phase_ff) && $stable(tick_ff))
      else $error("state moved while the result beat was stalled");

   a_event_from_timing: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(phase_ff) == PH_TIMING)
      else $error("press event raised outside the timing phase");

endmodule

// ----- rtl/five_way_short_long_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// five_way_short_long_press_classifier: joystick short/long press events
//
//   channel  direction  handshake               payload
//   req_     in         req_valid / req_ready   req_button_levels[4:0]
//   rsp_     out        rsp_valid / rsp_ready   rsp_button_code[2:0], rsp_long_press
//   csr_     in         psel/penable, pready=1  settle (0x0), long (0x4)
//
// One tick beat is taken per cycle unless the result beat stalls; a tick
// passes through the input register and the classifier step into the result
// register. The throughput is set by the combinational classifier step.
// Reset is synchronous and returns the limits to 50 and 950 ticks.
// A stalled result beat holds the step and the tick waiting in the input
// register; req_ready stays low while both are full and the stall lasts.
// ----------------------------------------------------------------------------
module five_way_short_long_press_classifier
   import fwsl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [4:0]  req_button_levels,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_button_code,
   output logic        rsp_long_press,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type          cfg;
   logic             in_valid_ff, in_valid_in;
   logic [LINES-1:0] in_levels_ff, in_levels_in;
   logic             tick_take;

   assign req_ready = ~in_valid_ff | tick_take;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_levels_in = in_levels_ff;
      if (req_ready) begin
         in_valid_in  = req_valid;
         in_levels_in = req_button_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_levels_ff <= in_levels_in;
   end

   fwsl_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   fwsl_core u_core (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .tick_valid      (in_valid_ff),
      .tick_levels     (in_levels_ff),
      .tick_take       (tick_take),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_button_code (rsp_button_code),
      .rsp_long_press  (rsp_long_press)
   );

endmodule

// ----- dv/tb_five_way_short_long_press_classifier.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_five_way_short_long_press_classifier: self-checking press classifier test
// Drives tick beats of joystick line levels, tracks the expected press events
// in a scoreboard that models the settle, timing and release phases, and
// compares every result beat field by field. Limits are reprogrammed between
// phases, from the reset values down to zero and up to the widest settings.
// ----------------------------------------------------------------------------
module tb_five_way_short_long_press_classifier;
   import fwsl_pkg::*;

   localparam int CYCLE_LIMIT  = 500000;
   localparam int DRAIN_CYCLES = 10;

   // Zero settle and a zero long limit (which behaves as one tick).
   localparam logic [4:0] ZERO_SETTLE_TICKS [14] = '{
      5'h00, 5'h1F, 5'h1F, 5'h1E, 5'h1F, 5'h00, 5'h10,
      5'h00, 5'h08, 5'h08, 5'h00, 5'h04, 5'h0C, 5'h00
   };
   // Settle of two, long limit of three: release while settling, then a long
   // press with a fresh edge during the wait for release.
   localparam logic [4:0] SHORT_LIMIT_TICKS [12] = '{
      5'h04, 5'h00, 5'h00, 5'h00, 5'h01, 5'h03,
      5'h07, 5'h05, 5'h01, 5'h01, 5'h11, 5'h00
   };

   typedef struct packed {
      logic [2:0] button_code;
      logic       long_press;
   } press_event_type;

   class press_scoreboard;
      logic [7:0]               settle_ticks  = SETTLE_RESET;
      logic [15:0]              long_ticks    = LONG_RESET;
      phase_type                phase         = PH_IDLE;
      logic [4:0]               prev_levels   = 5'h00;
      logic [2:0]               active_button = BTN_NONE;
      logic [COUNTER_WIDTH-1:0] tick_count    = '0;
      press_event_type          pending_presses[$];
      int                       error_count   = 0;

      function void set_register(logic reg_index, logic [31:0] value);
         if (reg_index == REG_SETTLE) begin
            settle_ticks = value[7:0];
         end else begin
            long_ticks = value[15:0];
         end
      endfunction

      function logic [2:0] first_risen(logic [4:0] rise);
         for (int i = 0; i < 5; i++) begin
            if (rise[i]) begin
               return 3'(i + 1);
            end
         end
         return BTN_NONE;
      endfunction

      // Long presses report the held line in the order right, up, down,
      // left, centre.
      function logic [2:0] long_press_line(logic [4:0] lv);
         if (lv[1]) return BTN_RIGHT;
         if (lv[0]) return BTN_UP;
         if (lv[2]) return BTN_DOWN;
         if (lv[3]) return BTN_LEFT;
         if (lv[4]) return BTN_CENTER;
         return BTN_NONE;
      endfunction

      function bit active_line_held(logic [4:0] lv);
         if (active_button < BTN_UP || active_button > BTN_CENTER) begin
            return 1'b0;
         end
         return lv[active_button - 1];
      endfunction

      function void count_tick();
         if (tick_count != '1) begin
            tick_count++;
         end
      endfunction

      function void take_tick(logic [4:0] lv);
         logic [4:0]  rise;
         logic [15:0] limit;
         logic [2:0]  code;
         rise  = lv & ~prev_levels;
         limit = (long_ticks == 16'd0) ? 16'd1 : long_ticks;
         case (phase)
            PH_IDLE: begin
               if (rise != 5'h00) begin
                  active_button = first_risen(rise);
                  tick_count    = '0;
                  phase         = (settle_ticks != 8'd0) ? PH_SETTLE : PH_TIMING;
               end
            end
            PH_SETTLE: begin
               count_tick();
               if (tick_count >= settle_ticks) begin
                  tick_count = '0;
                  phase      = PH_TIMING;
               end
            end
            PH_TIMING: begin
               if (!active_line_held(lv)) begin
                  pending_presses.push_back('{active_button, 1'b0});
                  phase = PH_IDLE;
               end else begin
                  count_tick();
                  if (tick_count >= limit) begin
                     code = long_press_line(lv);
                     if (code != BTN_NONE) begin
                        pending_presses.push_back('{code, 1'b1});
                     end
                     phase = PH_WAIT;
                  end
               end
            end
            default: begin
               if (!active_line_held(lv)) begin
                  phase = PH_IDLE;
               end
            end
         endcase
         prev_levels = lv;
      endfunction

      function void check_event(logic [2:0] button_code, logic long_press);
         press_event_type want;
         if (pending_presses.size() == 0) begin
            $error("unexpected result beat: button_code %0d, long_press %0d",
                   button_code, long_press);
            error_count++;
            return;
         end
         want = pending_presses.pop_front();
         if (button_code !== want.button_code) begin
            $error("button_code: expected %0d, actual %0d", want.button_code, button_code);
            error_count++;
         end
         if (long_press !== want.long_press) begin
            $error("long_press: expected %0d, actual %0d", want.long_press, long_press);
            error_count++;
         end
      endfunction

      function int pending();
         return pending_presses.size();
      endfunction
   endclass

   logic        clock             = 1'b0;
   logic        reset             = 1'b1;
   logic        req_valid         = 1'b0;
   logic        req_ready;
   logic [4:0]  req_button_levels = 5'h00;
   logic        rsp_valid;
   logic        rsp_ready         = 1'b0;
   logic [2:0]  rsp_button_code;
   logic        rsp_long_press;
   logic        csr_psel          = 1'b0;
   logic        csr_penable       = 1'b0;
   logic        csr_pwrite        = 1'b0;
   logic [2:0]  csr_paddr         = 3'd0;
   logic [31:0] csr_pwdata        = 32'd0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   press_scoreboard presses;
   bit              idling_on   = 1'b1;
   int              ticks_sent  = 0;
   int              cycle_count = 0;
   int              cur_settle  = int'(SETTLE_RESET);
   int              cur_long    = int'(LONG_RESET);

   five_way_short_long_press_classifier uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_button_levels (req_button_levels),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_button_code   (rsp_button_code),
      .rsp_long_press    (rsp_long_press),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Result side: stalls come in bursts.
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_ready = 1'b0;
            stall_left--;
         end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rsp_ready  = 1'b0;
            stall_left = $urandom_range(0, 7);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         presses.check_event(rsp_button_code, rsp_long_press);
      end
   end

   task automatic send_tick(input logic [4:0] lv);
      int gap;
      gap = 0;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 8);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_button_levels = lv;
      do @(posedge clock); while (!req_ready);
      presses.take_tick(lv);
      ticks_sent++;
   endtask

   // Lets the last beats run through, including those that give no result.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (presses.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic reg_index, input logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {reg_index, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      presses.set_register(reg_index, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Unused upper data bits carry junk, which the block must ignore.
   task automatic program_limits(input logic [7:0] settle, input logic [15:0] hold_limit);
      logic [31:0] junk;
      wait_idle();
      junk = $urandom;
      write_reg(REG_SETTLE, {junk[31:8], settle});
      junk = $urandom;
      write_reg(REG_LONG, {junk[31:16], hold_limit});
      cur_settle = int'(settle);
      cur_long   = int'(hold_limit);
   endtask

   // One press from idle: the edge beat, hold beats with the pressed line
   // kept high, a release beat, then enough low beats to leave settling.
   task automatic press_sequence(input logic [4:0] mask, input int hold);
      logic [4:0] active_bit;
      logic [4:0] lv;
      active_bit = mask & (~mask + 5'd1);
      repeat ($urandom_range(1, 2)) send_tick(5'h00);
      send_tick(mask);
      for (int i = 0; i < hold; i++) begin
         lv = mask;
         if ($urandom_range(0, 4) < 2) begin
            lv = 5'($urandom) | active_bit;
         end
         send_tick(lv);
      end
      lv = 5'h00;
      if ($urandom_range(0, 3) == 0) begin
         lv = 5'($urandom) & ~active_bit;
      end
      send_tick(lv);
      if (cur_settle > hold) begin
         repeat (cur_settle - hold) send_tick(5'h00);
      end
   endtask

   task automatic random_phase(input int target);
      int         first;
      int         base;
      int         hold;
      logic [4:0] mask;
      first = ticks_sent;
      while (ticks_sent - first < target) begin
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 5)) send_tick(5'($urandom));
            repeat (cur_settle + 2) send_tick(5'h00);
         end else begin
            if ($urandom_range(0, 9) < 7) begin
               mask = 5'(1 << $urandom_range(0, 4));
            end else begin
               mask = 5'($urandom_range(1, 31));
            end
            base = cur_settle + ((cur_long == 0) ? 1 : cur_long);
            case ($urandom_range(0, 4))
               0, 1:    hold = $urandom_range(0, base - 1);
               2:       hold = base - 1;
               3:       hold = base;
               default: hold = base + $urandom_range(1, 4);
            endcase
            press_sequence(mask, hold);
         end
      end
   endtask

   initial begin
      presses = new;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Reset limits: one short press.
      press_sequence(5'($urandom_range(1, 31)), 20);

      program_limits(8'd0, 16'd0);
      foreach (ZERO_SETTLE_TICKS[i]) send_tick(ZERO_SETTLE_TICKS[i]);
      program_limits(8'd2, 16'd3);
      foreach (SHORT_LIMIT_TICKS[i]) send_tick(SHORT_LIMIT_TICKS[i]);

      program_limits(8'd1, 16'd1);
      random_phase(45);
      idling_on = 1'b0;
      program_limits(8'd3, 16'd5);
      random_phase(45);
      idling_on = 1'b1;
      repeat (2) begin
         program_limits(8'($urandom_range(0, 6)), 16'($urandom_range(1, 12)));
         random_phase(45);
      end

      // Widest limits, back to back: a release while settling shows up as a
      // short press once the full settle count has passed.
      idling_on = 1'b0;
      program_limits(8'd255, 16'd65535);
      press_sequence(5'($urandom_range(1, 31)), 10);
      wait_idle();

      if (presses.error_count == 0 && presses.pending() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
